// ----- src/cartridge_bank_controller_unit_defines.svh -----
// assertion macros for the cartridge bank controller
// expects clk and arst_n in the scope of each use
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CBC_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cbc assertion failed");
`define CBC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cbc assertion failed");
`else
`define CBC_ASSERT_SAME(lbl, pre, post)
`define CBC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- src/cbc_pkg.sv -----
// types and constants of the cartridge bank controller
// no dependencies
package cbc_pkg;

	localparam int ROM_BANK_BYTES  = 16384;
	localparam int RAM_BANK_BYTES  = 8192;
	localparam int CLOCK_REG_COUNT = 5;
	localparam int ROM_OFS_W       = $clog2(ROM_BANK_BYTES);
	localparam int RAM_OFS_W       = $clog2(RAM_BANK_BYTES);
	localparam int BANK_NUM_W      = 14;
	localparam int REM_W           = 10;
	localparam int CFG_W           = 10;
	localparam int CLK_IDX_W       = 3;

	localparam logic [9:0] ROM_BANKS_LIMIT = 10'd512;
	localparam logic [7:0] NIBBLE_MASK     = 8'h0f;
	localparam logic [7:0] RAM_EN_CODE     = 8'h0a;
	localparam logic [7:0] MBC1_LOW_MASK   = 8'h1f;
	localparam logic [7:0] MBC3_LOW_MASK   = 8'h7f;
	localparam logic [7:0] MBC1_SEL_MASK   = 8'h03;
	localparam logic [7:0] OPEN_BUS        = 8'hff;
	localparam logic [7:0] BANK_ONE        = 8'h01;
	localparam logic [7:0] MBC3_RAM_SELS   = 8'h04;
	localparam logic [7:0] CLK_SEL_FIRST   = 8'h08;

	typedef enum logic [1:0] {
		KIND_ROM_ONLY = 2'd0,
		KIND_MBC1     = 2'd1,
		KIND_MBC3     = 2'd2,
		KIND_MBC5     = 2'd3
	} cbc_kind_t;

	typedef enum logic [1:0] {
		CFG_MAPPER_KIND    = 2'd0,
		CFG_ROM_BANK_COUNT = 2'd1,
		CFG_RAM_BANK_COUNT = 2'd2,
		CFG_BANKING_MODE   = 2'd3
	} cbc_cfg_idx_t;

	typedef enum logic [1:0] {
		OUT_ROM_FETCH  = 2'd0,
		OUT_READ_VALID = 2'd1,
		OUT_WRITE_DONE = 2'd2,
		OUT_ADDR_ERROR = 2'd3
	} cbc_outcome_t;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} cbc_op_t;

	typedef enum logic [2:0] {
		CLS_ROM_READ,
		CLS_CTRL_WRITE,
		CLS_RAM_READ,
		CLS_RAM_WRITE,
		CLS_BAD
	} cbc_class_t;

	typedef enum logic [1:0] {
		TGT_NONE,
		TGT_RAM,
		TGT_CLOCK
	} cbc_target_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] address;
		logic [7:0]  write_data;
	} cbc_request_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [22:0] rom_address;
		logic [1:0]  outcome;
	} cbc_response_t;

endpackage

// ----- src/cartridge_bank_controller_unit.sv -----
// cartridge bank mapper for rom-only, mbc1, mbc3 and mbc5 cartridges
// depends on cbc_pkg and cartridge_bank_controller_unit_defines.svh
//
// channel   signals                                  transfer
// request   start, busy, request                     start && !busy at clk rise
// response  done, response                           done high for one cycle
// config    cfg_we, cfg_index, cfg_data              cfg_we at clk rise
//
// after the accepting edge, the bank remainder unit works one bit per cycle over a 14-bit bank number
// then S_MEM serves the ram port, S_RESP registers the result, and done shows the strobe
// a new item is taken in the cycle the result strobe is shown
// the receiver cannot stall; busy holds off requests until the strobe cycle
// reset clears mapper and clock registers; cartridge ram is not cleared
`include "cartridge_bank_controller_unit_defines.svh"

module cartridge_bank_controller_unit
	import cbc_pkg::*;
#(
	parameter int RAM_BANKS_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cbc_request_t         request,
	output logic                 done,
	output cbc_response_t        response,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int RAM_DEPTH = RAM_BANKS_MAX * RAM_BANK_BYTES;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_MEM,
		S_RESP
	} state_t;

	state_t           state_q;
	cbc_kind_t        kind_q;
	logic [9:0]       rom_count_q;
	logic [4:0]       ram_count_q;
	logic             mode_q;
	logic             ram_en_q;
	logic [7:0]       rom_low_q;
	logic             rom_high_q;
	logic [7:0]       ram_sel_q;
	logic [7:0]       clk_regs_q [CLOCK_REG_COUNT];

	cbc_request_t     cmd_q;
	cbc_class_t       cls_q;
	cbc_target_t      tgt_q;
	logic [CLK_IDX_W-1:0] clk_idx_q;
	logic [BANK_NUM_W-1:0] dvd_q;
	logic [REM_W-1:0] div_q;
	logic [REM_W-1:0] rem_q;
	logic [3:0]       cnt_q;
	logic [7:0]       clk_byte_q;
	logic             done_q;
	cbc_response_t    result_q;
	cbc_response_t    resp_d;

	logic [7:0]       ram [RAM_DEPTH];
	logic [7:0]       ram_rd_q;
	logic [RAM_AW-1:0] ram_idx;
	logic             ram_we;

	logic             accept;
	cbc_class_t       acc_cls;
	cbc_target_t      acc_tgt;
	logic [BANK_NUM_W-1:0] acc_dvd;
	logic [REM_W-1:0] acc_div;
	logic [CLK_IDX_W-1:0] acc_clk_idx;
	logic [9:0]       rom_eff;
	logic [4:0]       ram_eff;
	logic [REM_W:0]   shifted;
	logic             sub_ok;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign response = result_q;

	// effective bank counts
	always_comb begin
		if (rom_count_q == 10'd0) begin
			rom_eff = 10'd1;
		end else if (rom_count_q > ROM_BANKS_LIMIT) begin
			rom_eff = ROM_BANKS_LIMIT;
		end else begin
			rom_eff = rom_count_q;
		end
		if (ram_count_q > 5'(RAM_BANKS_MAX)) begin
			ram_eff = 5'(RAM_BANKS_MAX);
		end else begin
			ram_eff = ram_count_q;
		end
	end

	// decode of the incoming access
	always_comb begin
		acc_cls     = CLS_BAD;
		acc_tgt     = TGT_NONE;
		acc_dvd     = '0;
		acc_div     = rom_eff;
		acc_clk_idx = CLK_IDX_W'(ram_sel_q - CLK_SEL_FIRST);
		if (!request.address[15]) begin
			if (request.opcode == OP_WRITE) begin
				acc_cls = CLS_CTRL_WRITE;
			end else begin
				acc_cls = CLS_ROM_READ;
				if (kind_q == KIND_ROM_ONLY) begin
					acc_dvd = BANK_NUM_W'(request.address[15:14]);
				end else if (!request.address[14]) begin
					if (kind_q == KIND_MBC1 && mode_q) begin
						acc_dvd = {1'b0, ram_sel_q, 5'd0};
					end
				end else begin
					unique case (kind_q)
						KIND_MBC1: acc_dvd = {1'b0, ram_sel_q, 5'd0} + BANK_NUM_W'(rom_low_q);
						KIND_MBC3: acc_dvd = BANK_NUM_W'(rom_low_q);
						KIND_MBC5: acc_dvd = BANK_NUM_W'({rom_high_q, rom_low_q});
						default:   acc_dvd = '0;
					endcase
				end
			end
		end else if (request.address[15:13] == 3'b101) begin
			acc_cls = (request.opcode == OP_WRITE) ? CLS_RAM_WRITE : CLS_RAM_READ;
			acc_div = REM_W'(ram_eff);
			if (kind_q != KIND_ROM_ONLY && ram_en_q) begin
				if (kind_q == KIND_MBC3) begin
					if (ram_sel_q < MBC3_RAM_SELS) begin
						if (ram_eff != 5'd0) begin
							acc_tgt = TGT_RAM;
							acc_dvd = BANK_NUM_W'(ram_sel_q);
						end
					end else if (ram_sel_q >= CLK_SEL_FIRST &&
						ram_sel_q < CLK_SEL_FIRST + 8'(CLOCK_REG_COUNT)) begin
						acc_tgt = TGT_CLOCK;
					end
				end else if (ram_eff != 5'd0) begin
					acc_tgt = TGT_RAM;
					if (!(kind_q == KIND_MBC1 && !mode_q)) begin
						acc_dvd = BANK_NUM_W'(ram_sel_q);
					end
				end
			end
		end
	end

	// restoring remainder step
	assign shifted = {rem_q, dvd_q[BANK_NUM_W-1]};
	assign sub_ok  = shifted >= {1'b0, div_q};

	assign ram_idx = RAM_AW'({rem_q, cmd_q.address[RAM_OFS_W-1:0]});
	assign ram_we  = (state_q == S_MEM) && (cls_q == CLS_RAM_WRITE) && (tgt_q == TGT_RAM);

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram[ram_idx] <= cmd_q.write_data;
		end
		ram_rd_q <= ram[ram_idx];
	end

	// result of the finished transfer
	always_comb begin
		resp_d = '0;
		unique case (cls_q)
			CLS_ROM_READ: begin
				resp_d.outcome     = OUT_ROM_FETCH;
				resp_d.rom_address = {rem_q[8:0], cmd_q.address[ROM_OFS_W-1:0]};
			end
			CLS_RAM_READ: begin
				resp_d.outcome = OUT_READ_VALID;
				unique case (tgt_q)
					TGT_RAM:   resp_d.read_data = ram_rd_q;
					TGT_CLOCK: resp_d.read_data = clk_byte_q;
					default:   resp_d.read_data = OPEN_BUS;
				endcase
			end
			CLS_CTRL_WRITE, CLS_RAM_WRITE: resp_d.outcome = OUT_WRITE_DONE;
			default: resp_d.outcome = OUT_ADDR_ERROR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_ROM_ONLY;
			rom_count_q <= 10'd2;
			ram_count_q <= 5'd0;
			mode_q      <= 1'b0;
			ram_en_q    <= 1'b0;
			rom_low_q   <= BANK_ONE;
			rom_high_q  <= 1'b0;
			ram_sel_q   <= 8'd0;
			for (int i = 0; i < CLOCK_REG_COUNT; i++) begin
				clk_regs_q[i] <= 8'd0;
			end
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == S_RESP);
			if (cfg_we) begin
				unique case (cbc_cfg_idx_t'(cfg_index))
					CFG_MAPPER_KIND:    kind_q      <= cbc_kind_t'(cfg_data[1:0]);
					CFG_ROM_BANK_COUNT: rom_count_q <= cfg_data;
					CFG_RAM_BANK_COUNT: ram_count_q <= cfg_data[4:0];
					CFG_BANKING_MODE:   mode_q      <= cfg_data[0];
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= request;
						cls_q     <= acc_cls;
						tgt_q     <= acc_tgt;
						clk_idx_q <= acc_clk_idx;
						dvd_q     <= acc_dvd;
						div_q     <= acc_div;
						rem_q     <= '0;
						cnt_q     <= 4'(BANK_NUM_W - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= sub_ok ? REM_W'(shifted - {1'b0, div_q}) : shifted[REM_W-1:0];
					dvd_q <= {dvd_q[BANK_NUM_W-2:0], 1'b0};
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= S_MEM;
					end
				end
				S_MEM: begin
					clk_byte_q <= clk_regs_q[clk_idx_q];
					if (cls_q == CLS_RAM_WRITE && tgt_q == TGT_CLOCK) begin
						clk_regs_q[clk_idx_q] <= cmd_q.write_data;
					end
					if (cls_q == CLS_CTRL_WRITE) begin
						priority case (kind_q)
							KIND_MBC1, KIND_MBC3: begin
								priority case (cmd_q.address[14:13])
									2'd0: ram_en_q <= ((cmd_q.write_data & NIBBLE_MASK)
										== RAM_EN_CODE);
									2'd1: begin
										if ((cmd_q.write_data & ((kind_q == KIND_MBC1) ?
											MBC1_LOW_MASK : MBC3_LOW_MASK)) == 8'd0) begin
											rom_low_q <= BANK_ONE;
										end else begin
											rom_low_q <= cmd_q.write_data & ((kind_q ==
												KIND_MBC1) ? MBC1_LOW_MASK : MBC3_LOW_MASK);
										end
									end
									2'd2: ram_sel_q <= (kind_q == KIND_MBC1) ?
										(cmd_q.write_data & MBC1_SEL_MASK) : cmd_q.write_data;
									default: ;
								endcase
							end
							KIND_MBC5: begin
								priority case (cmd_q.address[14:12])
									3'd0, 3'd1: begin
										if (cmd_q.write_data == 8'd0) begin
											ram_en_q <= 1'b0;
										end else if (cmd_q.write_data == RAM_EN_CODE) begin
											ram_en_q <= 1'b1;
										end
									end
									3'd2: rom_low_q  <= cmd_q.write_data;
									3'd3: rom_high_q <= cmd_q.write_data[0];
									3'd4, 3'd5: ram_sel_q <= cmd_q.write_data;
									default: ;
								endcase
							end
							default: ;
						endcase
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					result_q <= resp_d;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CBC_ASSERT_SAME(a_done_idle, done_q, state_q == S_IDLE)
	`CBC_ASSERT_NEXT(a_accept_div, accept, state_q == S_DIV)
	`CBC_ASSERT_NEXT(a_resp_done, state_q == S_RESP, done_q)
	`CBC_ASSERT_SAME(a_rom_no_data, done_q && result_q.outcome == OUT_ROM_FETCH,
		result_q.read_data == 8'd0)

endmodule

// ----- test/cartridge_bank_controller_unit_tb.sv -----
// self-checking testbench for cartridge_bank_controller_unit: directed accesses, then random
// bus traffic over several mapper settings, checked against a bank-mapping predictor
// depends on cbc_pkg and the cartridge_bank_controller_unit rtl
`timescale 1ns / 1ps

module cartridge_bank_controller_unit_tb;
	import cbc_pkg::*;

	localparam int RAM_BANKS = 16;
	localparam int RAM_BYTES = RAM_BANKS * RAM_BANK_BYTES;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 95;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		bit               is_reg;
		cbc_cfg_idx_t     reg_idx;
		logic [CFG_W-1:0] reg_val;
		cbc_request_t     req;
		bit               fixed;
		cbc_response_t    want;
	} script_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cbc_request_t     request;
	logic             done;
	cbc_response_t    response;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// mapper settings and state as the predictor sees them
	cbc_kind_t   cfg_kind;
	logic [9:0]  cfg_rom_banks;
	logic [4:0]  cfg_ram_banks;
	logic        cfg_mode;
	logic        ram_on;
	logic [7:0]  bank_low;
	logic        bank_high;
	logic [7:0]  bank_sel;
	logic [7:0]  cart_ram [0:RAM_BYTES-1];
	bit          cart_ram_set [0:RAM_BYTES-1];
	logic [7:0]  rtc [0:CLOCK_REG_COUNT-1];

	cbc_response_t responses_due [$];
	script_row_t   script [$];
	int            mismatches = 0;
	int            quiet_cycles = 0;

	cartridge_bank_controller_unit #(
		.RAM_BANKS_MAX(RAM_BANKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.response(response),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int rom_banks_eff();
		if (cfg_rom_banks == 0) return 1;
		if (cfg_rom_banks > ROM_BANKS_LIMIT) return ROM_BANKS_LIMIT;
		return cfg_rom_banks;
	endfunction

	function automatic int ram_banks_eff();
		return (cfg_ram_banks > RAM_BANKS) ? RAM_BANKS : cfg_ram_banks;
	endfunction

	function automatic cbc_target_t window_target(input logic [15:0] addr, output int slot);
		int sel;
		int a;
		sel = bank_sel;
		a = addr;
		slot = 0;
		if (cfg_kind == KIND_ROM_ONLY || !ram_on) return TGT_NONE;
		if (cfg_kind == KIND_MBC3) begin
			if (sel < MBC3_RAM_SELS) begin
				if (ram_banks_eff() == 0) return TGT_NONE;
				slot = (sel % ram_banks_eff()) * RAM_BANK_BYTES + a % RAM_BANK_BYTES;
				return TGT_RAM;
			end
			if (sel >= CLK_SEL_FIRST && sel < CLK_SEL_FIRST + CLOCK_REG_COUNT) begin
				slot = sel - CLK_SEL_FIRST;
				return TGT_CLOCK;
			end
			return TGT_NONE;
		end
		if (ram_banks_eff() == 0) return TGT_NONE;
		if (cfg_kind == KIND_MBC1 && !cfg_mode) sel = 0;
		slot = (sel % ram_banks_eff()) * RAM_BANK_BYTES + a % RAM_BANK_BYTES;
		return TGT_RAM;
	endfunction

	function automatic void control_write(input logic [15:0] addr, input logic [7:0] data);
		logic [7:0] low;
		if (cfg_kind == KIND_MBC1 || cfg_kind == KIND_MBC3) begin
			if (addr < 16'h2000) begin
				ram_on = ((data & NIBBLE_MASK) == RAM_EN_CODE);
			end else if (addr < 16'h4000) begin
				low = data & ((cfg_kind == KIND_MBC1) ? MBC1_LOW_MASK : MBC3_LOW_MASK);
				bank_low = (low == 8'h00) ? BANK_ONE : low;
			end else if (addr < 16'h6000) begin
				bank_sel = (cfg_kind == KIND_MBC1) ? (data & MBC1_SEL_MASK) : data;
			end
		end else if (cfg_kind == KIND_MBC5) begin
			if (addr < 16'h2000) begin
				if (data == 8'h00) ram_on = 1'b0;
				else if (data == RAM_EN_CODE) ram_on = 1'b1;
			end else if (addr < 16'h3000) begin
				bank_low = data;
			end else if (addr < 16'h4000) begin
				bank_high = data[0];
			end else if (addr < 16'h6000) begin
				bank_sel = data;
			end
		end
	endfunction

	function automatic cbc_response_t map_access(input cbc_request_t r);
		cbc_response_t rsp;
		cbc_target_t tgt;
		int a;
		int bank;
		int rom_lin;
		int slot;
		rsp = '0;
		rsp.outcome = OUT_ADDR_ERROR;
		a = r.address;
		if (a < 'h8000) begin
			if (r.opcode == OP_WRITE) begin
				control_write(r.address, r.write_data);
				rsp.outcome = OUT_WRITE_DONE;
			end else begin
				if (cfg_kind == KIND_ROM_ONLY) bank = a / ROM_BANK_BYTES;
				else if (a < 'h4000) bank = (cfg_kind == KIND_MBC1 && cfg_mode) ? bank_sel * 32 : 0;
				else if (cfg_kind == KIND_MBC1) bank = bank_sel * 32 + bank_low;
				else if (cfg_kind == KIND_MBC3) bank = bank_low;
				else bank = bank_high * 256 + bank_low;
				rom_lin = (bank % rom_banks_eff()) * ROM_BANK_BYTES + a % ROM_BANK_BYTES;
				rsp.rom_address = rom_lin[22:0];
				rsp.outcome = OUT_ROM_FETCH;
			end
		end else if (a >= 'ha000 && a < 'hc000) begin
			tgt = window_target(r.address, slot);
			if (r.opcode == OP_WRITE) begin
				if (tgt == TGT_RAM) begin
					cart_ram[slot] = r.write_data;
					cart_ram_set[slot] = 1'b1;
				end else if (tgt == TGT_CLOCK) begin
					rtc[slot] = r.write_data;
				end
				rsp.outcome = OUT_WRITE_DONE;
			end else begin
				rsp.read_data = OPEN_BUS;
				if (tgt == TGT_RAM) rsp.read_data = cart_ram[slot];
				else if (tgt == TGT_CLOCK) rsp.read_data = rtc[slot];
				rsp.outcome = OUT_READ_VALID;
			end
		end
		return rsp;
	endfunction

	function automatic cbc_request_t make_access();
		cbc_request_t r;
		int pick;
		int slot;
		r.opcode = cbc_op_t'($urandom_range(1));
		r.address = 16'($urandom);
		r.write_data = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 25) begin
			r.opcode = OP_WRITE;
			r.address = 16'($urandom_range(16'h7fff));
			if (r.address < 16'h2000) begin
				case ($urandom_range(3))
					0: r.write_data = RAM_EN_CODE;
					1: r.write_data = 8'h00;
					2: r.write_data = {4'($urandom), RAM_EN_CODE[3:0]};
					default: ;
				endcase
			end else if (r.address >= 16'h4000 && r.address < 16'h6000) begin
				case ($urandom_range(3))
					0: r.write_data = 8'($urandom_range(3));
					1: r.write_data = CLK_SEL_FIRST + 8'($urandom_range(CLOCK_REG_COUNT - 1));
					2: r.write_data = 8'($urandom_range(15));
					default: ;
				endcase
			end
		end else if (pick < 55) begin
			r.opcode = OP_READ;
			r.address = 16'($urandom_range(16'h7fff));
		end else if (pick < 90) begin
			case ($urandom_range(2))
				0: r.address = 16'ha000 + 16'($urandom_range(7));
				1: r.address = 16'hbff8 + 16'($urandom_range(7));
				default: r.address = 16'ha000 + 16'($urandom_range(16'h1fff));
			endcase
		end else if ($urandom_range(1)) begin
			r.address = 16'($urandom_range(16'h9fff, 16'h8000));
		end else begin
			r.address = 16'($urandom_range(16'hffff, 16'hc000));
		end
		// never read a ram byte that was not written yet
		if (r.opcode == OP_READ && r.address >= 16'ha000 && r.address < 16'hc000
			&& window_target(r.address, slot) == TGT_RAM && !cart_ram_set[slot])
			r.opcode = OP_WRITE;
		return r;
	endfunction

	function automatic script_row_t bus_row(cbc_op_t op, logic [15:0] a, logic [7:0] d);
		script_row_t row;
		row.is_reg = 1'b0;
		row.reg_idx = CFG_MAPPER_KIND;
		row.reg_val = '0;
		row.req = '{op, a, d};
		row.fixed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic script_row_t known_row(cbc_op_t op, logic [15:0] a, logic [7:0] d,
		cbc_outcome_t oc, logic [7:0] rd, logic [22:0] ra);
		script_row_t row;
		row = bus_row(op, a, d);
		row.fixed = 1'b1;
		row.want = '{rd, ra, oc};
		return row;
	endfunction

	function automatic script_row_t reg_row(cbc_cfg_idx_t idx, logic [CFG_W-1:0] v);
		script_row_t row;
		row = bus_row(OP_READ, 16'h0000, 8'h00);
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = v;
		return row;
	endfunction

	task automatic issue(input cbc_request_t req, input bit fixed, input cbc_response_t want);
		cbc_response_t predicted;
		@(negedge clk);
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = map_access(req);
		if (fixed) predicted = want;
		responses_due.push_back(predicted);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			request <= 25'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (responses_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input cbc_cfg_idx_t idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAPPER_KIND:    cfg_kind = cbc_kind_t'(v[1:0]);
			CFG_ROM_BANK_COUNT: cfg_rom_banks = v;
			CFG_RAM_BANK_COUNT: cfg_ram_banks = v[4:0];
			default:            cfg_mode = v[0];
		endcase
	endtask

	// result check, oldest expectation first
	always @(posedge clk) begin
		cbc_response_t want;
		if (arst_n && done) begin
			if (responses_due.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, got %h", $time, response);
				mismatches++;
			end else begin
				want = responses_due.pop_front();
				if (response.read_data !== want.read_data) begin
					$display("%0t: read_data expected %h got %h", $time, want.read_data,
						response.read_data);
					mismatches++;
				end
				if (response.rom_address !== want.rom_address) begin
					$display("%0t: rom_address expected %h got %h", $time, want.rom_address,
						response.rom_address);
					mismatches++;
				end
				if (response.outcome !== want.outcome) begin
					$display("%0t: outcome expected %0d got %0d", $time, want.outcome,
						response.outcome);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		cbc_request_t req;
		int rom_n;
		int ram_n;
		int idle_pct;
		int gap;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAPPER_KIND;
		cfg_data = '0;
		cfg_kind = KIND_ROM_ONLY;
		cfg_rom_banks = 10'd2;
		cfg_ram_banks = 5'd0;
		cfg_mode = 1'b0;
		ram_on = 1'b0;
		bank_low = BANK_ONE;
		bank_high = 1'b0;
		bank_sel = 8'h00;
		for (int i = 0; i < CLOCK_REG_COUNT; i++) rtc[i] = 8'h00;

		// reset settings: rom only, two banks, no ram
		script.push_back(known_row(OP_READ, 16'h0000, 8'h00, OUT_ROM_FETCH, 8'h00, 23'h000000));
		script.push_back(known_row(OP_READ, 16'h7fff, 8'h00, OUT_ROM_FETCH, 8'h00, 23'h007fff));
		script.push_back(known_row(OP_READ, 16'ha000, 8'h00, OUT_READ_VALID, OPEN_BUS, 23'h0));
		script.push_back(known_row(OP_WRITE, 16'h2000, 8'hff, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_WRITE, 16'hbfff, 8'h5a, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_READ, 16'h8000, 8'h00, OUT_ADDR_ERROR, 8'h00, 23'h0));
		script.push_back(known_row(OP_WRITE, 16'hffff, 8'hff, OUT_ADDR_ERROR, 8'h00, 23'h0));
		// mbc1, counts above their limits, upper bits select ram
		script.push_back(reg_row(CFG_MAPPER_KIND, 10'(KIND_MBC1)));
		script.push_back(reg_row(CFG_ROM_BANK_COUNT, 10'd1023));
		script.push_back(reg_row(CFG_RAM_BANK_COUNT, 10'd31));
		script.push_back(reg_row(CFG_BANKING_MODE, 10'd1));
		script.push_back(known_row(OP_WRITE, 16'h0000, 8'h0a, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_WRITE, 16'h2000, 8'h00, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_WRITE, 16'h4000, 8'hff, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(bus_row(OP_READ, 16'h0000, 8'h00));
		script.push_back(bus_row(OP_READ, 16'h7fff, 8'h00));
		script.push_back(bus_row(OP_WRITE, 16'hbfff, 8'hff));
		script.push_back(bus_row(OP_READ, 16'hbfff, 8'h00));
		// mbc3, zero rom count, clock registers
		script.push_back(reg_row(CFG_MAPPER_KIND, 10'(KIND_MBC3)));
		script.push_back(reg_row(CFG_ROM_BANK_COUNT, 10'd0));
		script.push_back(reg_row(CFG_RAM_BANK_COUNT, 10'd2));
		script.push_back(reg_row(CFG_BANKING_MODE, 10'd0));
		script.push_back(known_row(OP_WRITE, 16'h4000, 8'h0c, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(bus_row(OP_WRITE, 16'ha123, 8'ha5));
		script.push_back(bus_row(OP_READ, 16'ha000, 8'h00));
		script.push_back(known_row(OP_WRITE, 16'h4000, 8'h05, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_READ, 16'ha000, 8'h00, OUT_READ_VALID, OPEN_BUS, 23'h0));
		script.push_back(known_row(OP_READ, 16'h4000, 8'h00, OUT_ROM_FETCH, 8'h00, 23'h0));
		// mbc5, largest bank in the switchable window
		script.push_back(reg_row(CFG_MAPPER_KIND, 10'(KIND_MBC5)));
		script.push_back(reg_row(CFG_ROM_BANK_COUNT, 10'd512));
		script.push_back(reg_row(CFG_RAM_BANK_COUNT, 10'd16));
		script.push_back(known_row(OP_WRITE, 16'h3000, 8'hff, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_WRITE, 16'h2000, 8'hff, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_READ, 16'h7fff, 8'h00, OUT_ROM_FETCH, 8'h00, 23'h7fffff));
		script.push_back(known_row(OP_WRITE, 16'h0000, 8'h00, OUT_WRITE_DONE, 8'h00, 23'h0));
		script.push_back(known_row(OP_READ, 16'hbfff, 8'h00, OUT_READ_VALID, OPEN_BUS, 23'h0));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				settle();
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				issue(script[i].req, script[i].fixed, script[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin rom_n = 512; ram_n = 16; end
				1: begin rom_n = 1; ram_n = 0; end
				2: begin rom_n = 1023; ram_n = 31; end
				3: begin rom_n = 0; ram_n = 1; end
				default: begin
					rom_n = $urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(512, 1);
					ram_n = $urandom_range(16);
				end
			endcase
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 25;
				default: idle_pct = 60;
			endcase
			settle();
			write_reg(CFG_MAPPER_KIND, {8'($urandom), 2'(p % 4)});
			write_reg(CFG_ROM_BANK_COUNT, 10'(rom_n));
			write_reg(CFG_RAM_BANK_COUNT, {5'($urandom), 5'(ram_n)});
			write_reg(CFG_BANKING_MODE, {9'($urandom), 1'((p / 4) % 2)});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off mid-phase until the pipe is empty
				if (i == PHASE_ITEMS / 2) settle();
				req = make_access();
				issue(req, 1'b0, '0);
				gap = 0;
				if ($urandom_range(99) < idle_pct)
					gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(4, 1);
				pause(gap);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
